[sv/euler_rotation_translation_matrix_top_assert.svh]
// Assertion macros for the Euler matrix block
`ifndef EULER_ROTATION_TRANSLATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ROTATION_TRANSLATION_MATRIX_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define ERTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define ERTM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ertm_pkg.sv]
`timescale 1ns / 1ps
package ertm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANG_MAX        = 24;

  // internal Q30 word, with headroom for sums
  localparam int Q_W = 34;
  localparam logic signed [Q_W-1:0] Q30_ONE = Q_W'(64'sd1 << 30);

  // stream widths
  localparam int IN_W  = 144;
  localparam int OUT_W = 136;

  // pipeline register count
  localparam int NST = 13;

  // sine polynomial coefficients, Q30
  localparam logic signed [Q_W-1:0] C13 = 34'sd61;
  localparam logic signed [Q_W-1:0] COEF [6] = '{
    -34'sd3864, 34'sd172272, -34'sd5026995, 34'sd85569306,
    -34'sd693598669, 34'sd1686629713
  };

  // one pipeline stage worth of data
  typedef struct {
    logic signed [Q_W-1:0] t   [6];
    logic signed [Q_W-1:0] t2  [6];
    logic signed [Q_W-1:0] p   [6];
    logic signed [Q_W-1:0] sn  [3];
    logic signed [Q_W-1:0] cs  [3];
    logic signed [Q_W-1:0] pr  [10];
    logic signed [Q_W-1:0] q   [4];
    logic        [1:0]     quad [3];
    logic        [31:0]    pos [3];
    logic        [31:0]    ent [9];
  } pipe_t;

  // Q30 product, rounded half away from zero
  function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                 input logic signed [Q_W-1:0] b);
    logic             neg;
    logic [Q_W-1:0]   ua;
    logic [Q_W-1:0]   ub;
    logic [2*Q_W-1:0] pr;
    logic [Q_W-1:0]   mag;
    neg = a[Q_W-1] ^ b[Q_W-1];
    ua  = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
    ub  = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
    pr  = ua * ub;
    pr  = pr + ((2*Q_W)'(1) << 29);
    mag = pr[Q_W+29:30];
    return neg ? Q_W'(-mag) : Q_W'(mag);
  endfunction

endpackage

[sv/euler_rotation_translation_matrix_top.sv]
`timescale 1ns / 1ps
// Builds the 4x4 column-major X-Y-Z Euler model matrix from three binary
// angles and a Q16.16 translation, and sends it as four beats, one column per
// beat, column 0 first, tlast on column 3. The sine/cosine polynomials and the
// matrix products run in a 13-stage pipeline that takes one beat per cycle
// unless held; the output serializer holds one matrix and loads the next only
// as column 3 is sent, so the pipeline stalls while its last stage is full and
// the serializer is still sending (or out_tready is low).
module euler_rotation_translation_matrix_top #(
  parameter int ANGLE_BITS = ertm_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = ertm_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // angle_x, angle_y, angle_z (16 each), pos_x, pos_y, pos_z (32 each)
  input  logic [ertm_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // column (2), entry_row0..entry_row3 (32 each), 6 zero pad bits
  output logic [ertm_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import ertm_pkg::*;

  localparam int OUT_SHIFT = 30 - FRAC_BITS;

  // Q30 to output format, rounding half away from zero
  function automatic logic [31:0] to_out(input logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] u;
    logic [Q_W-1:0] rr;
    u  = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
    rr = (u + (Q_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    return v[Q_W-1] ? 32'(Q_W'(-rr)) : rr[31:0];
  endfunction

  pipe_t          pipe_r   [NST];
  pipe_t          pipe_nxt [NST];
  logic [NST-1:0] vld_r;
  pipe_t          mat_r;
  logic           ser_v_r;
  logic [1:0]     col_r;
  logic           adv;
  logic           ld_ok;
  logic           out_fire;

  assign out_fire  = ser_v_r && out_tready;
  assign ld_ok     = !ser_v_r || (out_fire && col_r == 2'd3);
  assign adv       = !vld_r[NST-1] || ld_ok;
  assign in_tready = adv;

  // stage logic
  always_comb begin
    logic [ANG_MAX-1:0]    ext;
    logic [ANGLE_BITS-1:0] a;
    logic [29:0]           t30;
    logic signed [Q_W-1:0] sb;
    logic signed [Q_W-1:0] cb;
    logic signed [Q_W-1:0] pv;
    pipe_nxt[0] = pipe_r[0];
    for (int j = 1; j < NST; j++) pipe_nxt[j] = pipe_r[j-1];

    // stage 0: angle reduction
    for (int i = 0; i < 3; i++) begin
      ext = {8'b0, in_tdata[16*i +: 16]};
      a   = ext[ANGLE_BITS-1:0];
      t30 = {a[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
      pipe_nxt[0].quad[i]  = a[ANGLE_BITS-1:ANGLE_BITS-2];
      pipe_nxt[0].t[2*i]   = Q_W'(t30);
      pipe_nxt[0].t[2*i+1] = Q30_ONE - Q_W'(t30);
      pipe_nxt[0].pos[i]   = in_tdata[48 + 32*i +: 32];
    end

    // stage 1: t squared
    for (int l = 0; l < 6; l++) pipe_nxt[1].t2[l] = qmul(pipe_r[0].t[l], pipe_r[0].t[l]);

    // stages 2..7: Horner steps
    for (int j = 2; j < 8; j++) begin
      for (int l = 0; l < 6; l++) begin
        pv = (j == 2) ? C13 : pipe_r[j-1].p[l];
        pipe_nxt[j].p[l] = COEF[j-2] + qmul(pv, pipe_r[j-1].t2[l]);
      end
    end

    // stage 8: times t, clamp to [0, 1]
    for (int l = 0; l < 6; l++) begin
      pv = qmul(pipe_r[7].p[l], pipe_r[7].t[l]);
      if (pv < 0) pv = '0;
      if (pv > Q30_ONE) pv = Q30_ONE;
      pipe_nxt[8].p[l] = pv;
    end

    // stage 9: quadrant signs and swap
    for (int i = 0; i < 3; i++) begin
      sb = pipe_r[8].p[2*i];
      cb = pipe_r[8].p[2*i+1];
      case (pipe_r[8].quad[i])
        2'd0: begin pipe_nxt[9].sn[i] = sb;  pipe_nxt[9].cs[i] = cb;  end
        2'd1: begin pipe_nxt[9].sn[i] = cb;  pipe_nxt[9].cs[i] = -sb; end
        2'd2: begin pipe_nxt[9].sn[i] = -sb; pipe_nxt[9].cs[i] = -cb; end
        default: begin pipe_nxt[9].sn[i] = -cb; pipe_nxt[9].cs[i] = sb; end
      endcase
    end

    // stage 10: pair products
    pipe_nxt[10].pr[0] = qmul(pipe_r[9].cs[1], pipe_r[9].cs[2]);
    pipe_nxt[10].pr[1] = qmul(pipe_r[9].cs[2], pipe_r[9].sn[0]);
    pipe_nxt[10].pr[2] = qmul(pipe_r[9].cs[0], pipe_r[9].sn[2]);
    pipe_nxt[10].pr[3] = qmul(pipe_r[9].sn[0], pipe_r[9].sn[2]);
    pipe_nxt[10].pr[4] = qmul(pipe_r[9].cs[0], pipe_r[9].cs[2]);
    pipe_nxt[10].pr[5] = qmul(pipe_r[9].cs[1], pipe_r[9].sn[2]);
    pipe_nxt[10].pr[6] = qmul(pipe_r[9].sn[0], pipe_r[9].sn[1]);
    pipe_nxt[10].pr[7] = qmul(pipe_r[9].cs[0], pipe_r[9].sn[1]);
    pipe_nxt[10].pr[8] = qmul(pipe_r[9].cs[1], pipe_r[9].sn[0]);
    pipe_nxt[10].pr[9] = qmul(pipe_r[9].cs[0], pipe_r[9].cs[1]);

    // stage 11: triple products
    pipe_nxt[11].q[0] = qmul(pipe_r[10].pr[1], pipe_r[10].sn[1]);
    pipe_nxt[11].q[1] = qmul(pipe_r[10].pr[4], pipe_r[10].sn[1]);
    pipe_nxt[11].q[2] = qmul(pipe_r[10].pr[6], pipe_r[10].sn[2]);
    pipe_nxt[11].q[3] = qmul(pipe_r[10].pr[7], pipe_r[10].sn[2]);

    // stage 12: sums and output rounding
    pipe_nxt[12].ent[0] = to_out(pipe_r[11].pr[0]);
    pipe_nxt[12].ent[1] = to_out(pipe_r[11].q[0] + pipe_r[11].pr[2]);
    pipe_nxt[12].ent[2] = to_out(pipe_r[11].pr[3] - pipe_r[11].q[1]);
    pipe_nxt[12].ent[3] = to_out(-pipe_r[11].pr[5]);
    pipe_nxt[12].ent[4] = to_out(pipe_r[11].pr[4] - pipe_r[11].q[2]);
    pipe_nxt[12].ent[5] = to_out(pipe_r[11].pr[1] + pipe_r[11].q[3]);
    pipe_nxt[12].ent[6] = to_out(pipe_r[11].sn[1]);
    pipe_nxt[12].ent[7] = to_out(-pipe_r[11].pr[8]);
    pipe_nxt[12].ent[8] = to_out(pipe_r[11].pr[9]);
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  // column serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      col_r   <= 2'd0;
    end else begin
      if (out_fire) col_r <= col_r + 2'd1;
      if (ld_ok) ser_v_r <= vld_r[NST-1];
    end
  end

  // serializer matrix hold
  always_ff @(posedge clk) begin
    if (ld_ok && vld_r[NST-1]) begin
      mat_r <= pipe_r[NST-1];
    end
  end

  // output beat mux
  always_comb begin
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    r3 = '0;
    case (col_r)
      2'd0: begin r0 = mat_r.ent[0]; r1 = mat_r.ent[1]; r2 = mat_r.ent[2]; end
      2'd1: begin r0 = mat_r.ent[3]; r1 = mat_r.ent[4]; r2 = mat_r.ent[5]; end
      2'd2: begin r0 = mat_r.ent[6]; r1 = mat_r.ent[7]; r2 = mat_r.ent[8]; end
      default: begin
        r0 = mat_r.pos[0]; r1 = mat_r.pos[1]; r2 = mat_r.pos[2];
        r3 = 32'(64'd1 << FRAC_BITS);
      end
    endcase
    out_tdata  = {6'b0, r3, r2, r1, r0, col_r};
    out_tlast  = (col_r == 2'd3);
    out_tvalid = ser_v_r;
  end

endmodule

[sv/ertm_checker.sv]
`timescale 1ns / 1ps
`include "euler_rotation_translation_matrix_top_assert.svh"
module ertm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ertm_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tlast
);
  // a stalled beat holds
  `ERTM_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled beat changed")
  // a matrix is sent without gaps once begun
  `ERTM_ASSERT_NXT(a_cols, out_tvalid && out_tready && !out_tlast, out_tvalid, "matrix cut short")
  // tlast marks column 3 only
  `ERTM_ASSERT_IMP(a_last, out_tvalid, out_tlast == (out_tdata[1:0] == 2'd3), "tlast mismatch")
  // row 3 is zero on rotation columns
  `ERTM_ASSERT_IMP(a_row3, out_tvalid && !out_tlast, out_tdata[129:98] == 32'd0, "row 3 not zero")
endmodule

bind euler_rotation_translation_matrix_top ertm_checker u_ertm_checker (.*);
